// ----- hw/rtl/rlebd_pkg.sv -----
// Shared types and codes for the truecolor RLE bitmap decoder.
// No dependencies; used by the front queue, the parser back end and the top level.
`timescale 1ns / 1ps

package rlebd_pkg;

    // Number of words the front queue holds between the two halves
    localparam int QUEUE_DEPTH = 4;

    // Config register indexes
    localparam logic [1:0] REG_BPP    = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // Result kinds carried on the master-side tuser
    typedef enum logic [1:0] {
        KIND_FILL = 2'd0,
        KIND_LIT  = 2'd1,
        KIND_END  = 2'd2,
        KIND_ERR  = 2'd3
    } kind_t;

    // Byte class decided at the front, used as count test and escape decode
    typedef enum logic [1:0] {
        BC_ZERO = 2'd0,
        BC_ONE  = 2'd1,
        BC_TWO  = 2'd2,
        BC_MANY = 2'd3
    } byte_class_t;

    // One queued stream word
    typedef struct packed {
        logic [7:0]  data;
        logic        start;
        byte_class_t cls;
    } item_t;

endpackage

// ----- hw/rtl/rlebd_front.sv -----
// Front end: accepts stream words, classifies the byte and queues it.
// Depends on rlebd_pkg.
`timescale 1ns / 1ps

module rlebd_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_data,
    input  logic            in_start,
    output logic            item_valid,
    output rlebd_pkg::item_t item,
    input  logic            item_pop
);

    localparam int PW = $clog2(rlebd_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(rlebd_pkg::QUEUE_DEPTH + 1);

    rlebd_pkg::item_t  queue_reg [rlebd_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic              push;
    rlebd_pkg::item_t  new_item;

    assign in_ready   = count_reg != CW'(rlebd_pkg::QUEUE_DEPTH);
    assign push       = in_valid && in_ready;
    assign item_valid = count_reg != '0;
    assign item       = queue_reg[rd_ptr_reg];

    // Classify the byte for the parser
    always_comb
    begin
        new_item.data  = in_data;
        new_item.start = in_start;
        unique case (in_data)
            8'd0:    new_item.cls = rlebd_pkg::BC_ZERO;
            8'd1:    new_item.cls = rlebd_pkg::BC_ONE;
            8'd2:    new_item.cls = rlebd_pkg::BC_TWO;
            default: new_item.cls = rlebd_pkg::BC_MANY;
        endcase
    end

    // Store on push
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (item_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !item_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (!push && item_pop)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(rlebd_pkg::QUEUE_DEPTH))
        else $error("queue fill count past depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> count_reg != '0)
        else $error("queue popped while empty");
`endif

endmodule

// ----- hw/rtl/rlebd_back.sv -----
// Back end: parses queued bytes into frame-write commands with bounds checks.
// Depends on rlebd_pkg; geometry comes registered from the top level.
`timescale 1ns / 1ps

module rlebd_back
#(
    parameter int SW = 15,
    parameter int FW = 27,
    parameter int NW = 27,
    parameter int RST_NLO = 1920
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             bpp4,
    input  logic [SW-1:0]    stride,
    input  logic [FW-1:0]    fsize,
    input  logic             item_valid,
    input  rlebd_pkg::item_t item,
    output logic             item_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       out_kind,
    output logic [25:0]      out_offset,
    output logic [31:0]      out_pixel,
    output logic [7:0]       out_run
);

    localparam int XW = ((NW > 8 + SW) ? NW : 8 + SW) + 2;

    typedef enum logic [2:0] {
        PH_COUNT, PH_FILL, PH_ESC, PH_DX, PH_DY, PH_LIT
    } phase_t;

    function automatic logic [9:0] times_bpp(input logic [7:0] v, input logic four);
        logic [9:0] w;
        w = {2'b00, v};
        return four ? (w << 2) : ((w << 1) + w);
    endfunction

    phase_t        phase_reg, phase_next, cur_phase;
    logic [7:0]    count_reg, count_next, cur_count;
    logic [7:0]    dx_reg, dx_next, cur_dx;
    logic [31:0]   acc_reg, acc_next, cur_acc, acc_new;
    logic [1:0]    idx_reg, idx_next, cur_idx;
    logic [NW-1:0] wo_reg, wo_next, cur_wo;
    logic [NW-1:0] nlo_reg, nlo_next, cur_nlo;
    logic          halted_reg, halted_next, cur_halted;
    logic          out_valid_reg;
    logic [1:0]    kind_reg, kind_next;
    logic [25:0]   offset_reg, offset_next;
    logic [31:0]   pixel_reg, pixel_next;
    logic [7:0]    run_reg, run_next;
    logic          emit;
    logic          px_done;
    logic [XW-1:0] fs_x, wo_x, fill_end, esc_end, wo_dx, wo_dy;
    logic [8+SW-1:0] dy_step;

    assign item_pop   = item_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_kind   = kind_reg;
    assign out_offset = offset_reg;
    assign out_pixel  = pixel_reg;
    assign out_run    = run_reg;

    // Take chunk start as a parser reset ahead of the byte
    always_comb
    begin
        cur_phase  = item.start ? PH_COUNT : phase_reg;
        cur_count  = item.start ? 8'd0 : count_reg;
        cur_dx     = item.start ? 8'd0 : dx_reg;
        cur_acc    = item.start ? 32'd0 : acc_reg;
        cur_idx    = item.start ? 2'd0 : idx_reg;
        cur_wo     = item.start ? '0 : wo_reg;
        cur_nlo    = item.start ? NW'(stride) : nlo_reg;
        cur_halted = item.start ? 1'b0 : halted_reg;
    end

    // Pixel assembly and bounds arithmetic
    always_comb
    begin
        acc_new  = cur_acc | (32'(item.data) << {cur_idx, 3'b000});
        px_done  = bpp4 ? (cur_idx == 2'd3) : (cur_idx == 2'd2);
        fs_x     = XW'(fsize);
        wo_x     = XW'(cur_wo);
        fill_end = wo_x + XW'(times_bpp(cur_count, bpp4));
        esc_end  = wo_x + XW'(times_bpp(item.data, bpp4));
        wo_dx    = wo_x + XW'(times_bpp(cur_dx, bpp4));
        dy_step  = item.data * stride;
        wo_dy    = wo_dx + XW'(dy_step);
    end

    // Parser step
    always_comb
    begin
        phase_next  = cur_phase;
        count_next  = cur_count;
        dx_next     = cur_dx;
        acc_next    = cur_acc;
        idx_next    = cur_idx;
        wo_next     = cur_wo;
        nlo_next    = cur_nlo;
        halted_next = cur_halted;
        emit        = 1'b0;
        kind_next   = rlebd_pkg::KIND_ERR;
        offset_next = 26'd0;
        pixel_next  = 32'd0;
        run_next    = 8'd0;
        if (!cur_halted)
        begin
            unique case (cur_phase)
                PH_COUNT:
                begin
                    acc_next = 32'd0;
                    idx_next = 2'd0;
                    if (item.cls != rlebd_pkg::BC_ZERO)
                    begin
                        count_next = item.data;
                        phase_next = PH_FILL;
                    end
                    else
                    begin
                        phase_next = PH_ESC;
                    end
                end
                PH_FILL:
                begin
                    acc_next = acc_new;
                    idx_next = cur_idx + 2'd1;
                    if (px_done)
                    begin
                        idx_next   = 2'd0;
                        phase_next = PH_COUNT;
                        emit       = 1'b1;
                        if (fill_end >= fs_x)
                        begin
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            kind_next   = rlebd_pkg::KIND_FILL;
                            offset_next = 26'(cur_wo);
                            pixel_next  = acc_new;
                            run_next    = cur_count;
                            wo_next     = NW'(fill_end);
                        end
                    end
                end
                PH_ESC:
                begin
                    case (item.cls)
                        rlebd_pkg::BC_ZERO:
                        begin
                            phase_next = PH_COUNT;
                            if (XW'(cur_nlo) > fs_x)
                            begin
                                emit        = 1'b1;
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                wo_next  = cur_nlo;
                                nlo_next = NW'(XW'(cur_nlo) + XW'(stride));
                            end
                        end
                        rlebd_pkg::BC_ONE:
                        begin
                            phase_next  = PH_COUNT;
                            emit        = 1'b1;
                            halted_next = 1'b1;
                            kind_next   = rlebd_pkg::KIND_END;
                        end
                        rlebd_pkg::BC_TWO:
                        begin
                            phase_next = PH_DX;
                        end
                        default:
                        begin
                            if (esc_end >= fs_x)
                            begin
                                phase_next  = PH_COUNT;
                                emit        = 1'b1;
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                count_next = item.data;
                                acc_next   = 32'd0;
                                idx_next   = 2'd0;
                                phase_next = PH_LIT;
                            end
                        end
                    endcase
                end
                PH_DX:
                begin
                    dx_next    = item.data;
                    phase_next = PH_DY;
                end
                PH_DY:
                begin
                    phase_next = PH_COUNT;
                    if (wo_dx >= fs_x || wo_dy >= fs_x)
                    begin
                        emit        = 1'b1;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        wo_next  = NW'(wo_dy);
                        nlo_next = NW'(XW'(cur_nlo) + XW'(dy_step));
                    end
                end
                PH_LIT:
                begin
                    acc_next = acc_new;
                    idx_next = cur_idx + 2'd1;
                    if (px_done)
                    begin
                        idx_next    = 2'd0;
                        acc_next    = 32'd0;
                        emit        = 1'b1;
                        kind_next   = rlebd_pkg::KIND_LIT;
                        offset_next = 26'(cur_wo);
                        pixel_next  = acc_new;
                        run_next    = 8'd1;
                        wo_next     = NW'(wo_x + XW'(bpp4 ? 3'd4 : 3'd3));
                        count_next  = cur_count - 8'd1;
                        if (cur_count == 8'd1)
                        begin
                            phase_next = PH_COUNT;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_COUNT;
                end
            endcase
        end
    end

    // Hold parser state and the output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_COUNT;
            count_reg     <= 8'd0;
            dx_reg        <= 8'd0;
            acc_reg       <= 32'd0;
            idx_reg       <= 2'd0;
            wo_reg        <= '0;
            nlo_reg       <= NW'(RST_NLO);
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= 2'd0;
            offset_reg    <= 26'd0;
            pixel_reg     <= 32'd0;
            run_reg       <= 8'd0;
        end
        else
        begin
            if (item_pop)
            begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                dx_reg     <= dx_next;
                acc_reg    <= acc_next;
                idx_reg    <= idx_next;
                wo_reg     <= wo_next;
                nlo_reg    <= nlo_next;
                halted_reg <= halted_next;
            end
            // Load a new word, or drop the old one once taken
            if (item_pop && emit)
            begin
                out_valid_reg <= 1'b1;
                kind_reg      <= kind_next;
                offset_reg    <= offset_next;
                pixel_reg     <= pixel_next;
                run_reg       <= run_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_pop && emit && (kind_next == rlebd_pkg::KIND_END ||
                              kind_next == rlebd_pkg::KIND_ERR)) |=> halted_reg)
        else $error("end or error did not halt the parser");

    a_lit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LIT) |-> count_reg != 8'd0)
        else $error("literal phase with zero pixels left");
`endif

endmodule

// ----- hw/rtl/rle_truecolor_bitmap_decoder_top.sv -----
// Top level of the truecolor RLE bitmap decoder: config registers, frame geometry,
// front queue and parser back end. Depends on rlebd_pkg, rlebd_front, rlebd_back.
`timescale 1ns / 1ps

// Decodes an inflated 24/32-bit bitmap RLE stream into frame-write commands.
// One byte enters per cycle while the queue has room, and at most one command
// leaves per byte; the parser takes one byte per clock while the output is not
// stalled, and an input word passes through the queue and the output register on
// its way to the output. A four-word queue separates input acceptance from the
// parser, and the parser holds while a command waits untaken in the output
// register. Line stride and frame size are registered from the config registers
// and settle in the cycle after a write. The dy move check (one 8 by stride
// multiply, two adds and a compare) sets the parser's critical path.
module rle_truecolor_bitmap_decoder_top
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_tuser,   // [0] chunk_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [25:0] byte_offset, [57:26] pixel_value,
                                   // [65:58] run_length, [71:66] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int SW = $clog2(MAX_WIDTH * 4 + 1);
    localparam int FW = $clog2(MAX_WIDTH * MAX_HEIGHT * 4 + 1);
    localparam int NW = $clog2(MAX_WIDTH * MAX_HEIGHT * 4 + MAX_WIDTH * 4 + 1);
    localparam int RST_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int RST_H = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;
    localparam int RST_STRIDE = RST_W * 3;
    localparam int RST_FSIZE  = RST_STRIDE * RST_H;

    logic [2:0]    bpp_reg;
    logic [12:0]   width_reg;
    logic [12:0]   height_reg;
    logic          bpp4_reg;
    logic [WW-1:0] ew;
    logic [HW-1:0] eh;
    logic [SW-1:0] stride_reg, stride_next;
    logic [FW-1:0] fsize_reg;

    logic             item_valid;
    logic             item_pop;
    rlebd_pkg::item_t item;
    logic [1:0]       kind;
    logic [25:0]      offset;
    logic [31:0]      pixel;
    logic [7:0]       run;

    // Write config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg    <= 3'd3;
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rlebd_pkg::REG_BPP:    bpp_reg    <= cfg_data[2:0];
                rlebd_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                rlebd_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Saturate geometry and form stride
    always_comb
    begin
        ew = (32'(width_reg) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_reg);
        eh = (32'(height_reg) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_reg);
        stride_next = (bpp_reg >= 3'd4) ? (SW'(ew) << 2) : ((SW'(ew) << 1) + SW'(ew));
    end

    // Register stride and frame size together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp4_reg   <= 1'b0;
            stride_reg <= SW'(RST_STRIDE);
            fsize_reg  <= FW'(RST_FSIZE);
        end
        else
        begin
            bpp4_reg   <= bpp_reg >= 3'd4;
            stride_reg <= stride_next;
            fsize_reg  <= FW'(stride_next) * FW'(eh);
        end
    end

    rlebd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .in_start   (s_tuser[0]),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    rlebd_back #(.SW(SW), .FW(FW), .NW(NW), .RST_NLO(RST_STRIDE)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .bpp4       (bpp4_reg),
        .stride     (stride_reg),
        .fsize      (fsize_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (kind),
        .out_offset (offset),
        .out_pixel  (pixel),
        .out_run    (run)
    );

    assign m_tuser = kind;
    assign m_tdata = {6'd0, run, pixel, offset};

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the truecolor RLE bitmap decoder top level.
// Depends on rlebd_pkg and rle_truecolor_bitmap_decoder_top; a clocked driver and
// monitor run against an in-bench decoder model across several geometry settings.
`timescale 1ns / 1ps

module tb_top;

    localparam int WIDTH_CAP   = 4096;
    localparam int HEIGHT_CAP  = 4096;
    localparam int SETTLE_CYC  = 20;
    localparam int STALL_LIMIT = 2000;

    typedef enum int {PH_COUNT, PH_FILL, PH_ESC, PH_DX, PH_DY, PH_LIT} phase_t;

    typedef struct {
        logic [7:0] data;
        logic       start;
    } stream_word_t;

    typedef struct {
        rlebd_pkg::kind_t kind;
        logic [25:0]      offset;
        logic [31:0]      pixel;
        logic [7:0]       run;
    } write_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;

    rle_truecolor_bitmap_decoder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stream_word_t pending_words[$];
    write_cmd_t   expected_cmds[$];
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           mismatches = 0;
    int           stall_count = 0;
    bit           next_start = 1'b1;

    // Decoder model state and its copy of the registers
    logic [2:0]  mdl_bpp = 3'd3;
    logic [12:0] mdl_width = 13'd640;
    logic [12:0] mdl_height = 13'd480;
    phase_t      mdl_phase;
    int unsigned mdl_count;
    int unsigned mdl_dx;
    logic [31:0] mdl_acc;
    int unsigned mdl_idx;
    longint      mdl_wofs;
    longint      mdl_next_line;
    bit          mdl_halted;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint pixel_bytes();
        if (mdl_bpp < 3) return 3;
        if (mdl_bpp > 4) return 4;
        return mdl_bpp;
    endfunction

    function automatic longint line_stride();
        longint w;
        w = (mdl_width > WIDTH_CAP) ? WIDTH_CAP : mdl_width;
        return w * pixel_bytes();
    endfunction

    function automatic longint frame_bytes();
        longint h;
        h = (mdl_height > HEIGHT_CAP) ? HEIGHT_CAP : mdl_height;
        return line_stride() * h;
    endfunction

    function automatic longint bytes_left();
        longint fs;
        fs = frame_bytes();
        return (mdl_wofs < fs) ? fs - mdl_wofs : 0;
    endfunction

    function automatic void restart_parser();
        mdl_phase     = PH_COUNT;
        mdl_count     = 0;
        mdl_dx        = 0;
        mdl_acc       = '0;
        mdl_idx       = 0;
        mdl_wofs      = 0;
        mdl_next_line = line_stride();
        mdl_halted    = 1'b0;
    endfunction

    function automatic void push_cmd(rlebd_pkg::kind_t k, longint ofs, logic [31:0] pix,
                                     int unsigned run);
        write_cmd_t c;
        c.kind   = k;
        c.offset = ofs[25:0];
        c.pixel  = pix;
        c.run    = run[7:0];
        expected_cmds.push_back(c);
    endfunction

    function automatic void halt_with(rlebd_pkg::kind_t k);
        mdl_halted = 1'b1;
        mdl_phase  = PH_COUNT;
        push_cmd(k, 0, '0, 0);
    endfunction

    // Collect one pixel byte; true once the pixel is whole
    function automatic bit gather_pixel(logic [7:0] b);
        mdl_acc = mdl_acc | (32'(b) << (8 * (mdl_idx & 3)));
        if (mdl_idx + 1 >= pixel_bytes())
        begin
            mdl_idx = 0;
            return 1'b1;
        end
        mdl_idx = (mdl_idx + 1) & 3;
        return 1'b0;
    endfunction

    // Advance the decoder model by one stream byte
    function automatic void decode_byte(logic [7:0] b, logic st);
        longint bpp;
        longint step;
        logic [31:0] pix;
        if (st)
            restart_parser();
        if (mdl_halted)
            return;
        bpp = pixel_bytes();
        case (mdl_phase)
            PH_COUNT:
            begin
                mdl_acc = '0;
                mdl_idx = 0;
                if (b != 0)
                begin
                    mdl_count = b;
                    mdl_phase = PH_FILL;
                end
                else
                    mdl_phase = PH_ESC;
            end
            PH_FILL:
            begin
                if (gather_pixel(b))
                begin
                    mdl_phase = PH_COUNT;
                    step = longint'(mdl_count) * bpp;
                    if (step >= bytes_left())
                        halt_with(rlebd_pkg::KIND_ERR);
                    else
                    begin
                        push_cmd(rlebd_pkg::KIND_FILL, mdl_wofs, mdl_acc, mdl_count);
                        mdl_wofs += step;
                    end
                end
            end
            PH_ESC:
            begin
                if (b == 0)
                begin
                    if (mdl_next_line > frame_bytes())
                        halt_with(rlebd_pkg::KIND_ERR);
                    else
                    begin
                        mdl_wofs      = mdl_next_line;
                        mdl_next_line = mdl_wofs + line_stride();
                        mdl_phase     = PH_COUNT;
                    end
                end
                else if (b == 1)
                    halt_with(rlebd_pkg::KIND_END);
                else if (b == 2)
                    mdl_phase = PH_DX;
                else if (longint'(b) * bpp >= bytes_left())
                    halt_with(rlebd_pkg::KIND_ERR);
                else
                begin
                    mdl_count = b;
                    mdl_acc   = '0;
                    mdl_idx   = 0;
                    mdl_phase = PH_LIT;
                end
            end
            PH_DX:
            begin
                mdl_dx    = b;
                mdl_phase = PH_DY;
            end
            PH_DY:
            begin
                mdl_phase = PH_COUNT;
                step = longint'(mdl_dx) * bpp;
                if (step >= bytes_left())
                    halt_with(rlebd_pkg::KIND_ERR);
                else
                begin
                    mdl_wofs += step;
                    step = longint'(b) * line_stride();
                    if (step >= bytes_left())
                        halt_with(rlebd_pkg::KIND_ERR);
                    else
                    begin
                        mdl_wofs      += step;
                        mdl_next_line += step;
                    end
                end
            end
            PH_LIT:
            begin
                if (gather_pixel(b))
                begin
                    pix     = mdl_acc;
                    mdl_acc = '0;
                    push_cmd(rlebd_pkg::KIND_LIT, mdl_wofs, pix, 1);
                    mdl_wofs += bpp;
                    mdl_count = (mdl_count - 1) & 8'hFF;
                    if (mdl_count == 0)
                        mdl_phase = PH_COUNT;
                end
            end
            default: mdl_phase = PH_COUNT;
        endcase
    endfunction

    // Driver: present queued words, drop valid at random between words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                decode_byte(s_tdata, s_tuser[0]);
                void'(pending_words.pop_front());
            end
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_words[0].data;
                s_tuser  <= pending_words[0].start;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Monitor: stall at random, compare each command with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        write_cmd_t c;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected command: kind %0d offset %0h",
                                 m_tuser, m_tdata[25:0]);
                end
                else
                begin
                    c = expected_cmds.pop_front();
                    if (m_tuser != c.kind || m_tdata[25:0] != c.offset
                        || m_tdata[57:26] != c.pixel || m_tdata[65:58] != c.run)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp kind %0d ofs %0h pix %0h run %0d,",
                                      " got kind %0d ofs %0h pix %0h run %0d"},
                                     c.kind, c.offset, c.pixel, c.run, m_tuser,
                                     m_tdata[25:0], m_tdata[57:26], m_tdata[65:58]);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            stall_count <= 0;
        else if (stall_count >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            stall_count <= stall_count + 1;
    end

    task automatic put_word(logic [7:0] b);
        stream_word_t w;
        w.data  = b;
        w.start = next_start;
        next_start = 1'b0;
        pending_words.push_back(w);
    endtask

    task automatic put_pixel(logic [31:0] p);
        for (int i = 0; i < pixel_bytes(); i++)
            put_word(p[8*i +: 8]);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            rlebd_pkg::REG_BPP:    mdl_bpp = val[2:0];
            rlebd_pkg::REG_WIDTH:  mdl_width = val;
            rlebd_pkg::REG_HEIGHT: mdl_height = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || s_tvalid || expected_cmds.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Mostly well-formed commands with random content, some noise and restarts
    task automatic random_stream(int words);
        int sel;
        int n;
        while (pending_words.size() < words)
        begin
            sel = $urandom_range(99);
            if (sel < 35)
            begin
                put_word(8'(($urandom_range(9) == 0) ? $urandom_range(1, 255)
                                                     : $urandom_range(1, 8)));
                put_pixel($urandom);
            end
            else if (sel < 50)
            begin
                n = ($urandom_range(7) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 5);
                put_word(8'd0);
                put_word(8'(n));
                for (int i = 0; i < n && i < 6; i++)
                    put_pixel($urandom);
            end
            else if (sel < 60)
            begin
                put_word(8'd0);
                put_word(8'd0);
            end
            else if (sel < 70)
            begin
                put_word(8'd0);
                put_word(8'd2);
                put_word(8'(($urandom_range(9) == 0) ? $urandom_range(255)
                                                     : $urandom_range(4)));
                put_word(8'(($urandom_range(9) == 0) ? $urandom_range(255)
                                                     : $urandom_range(2)));
            end
            else if (sel < 74)
            begin
                put_word(8'd0);
                put_word(8'd1);
                next_start = 1'b1;
            end
            else if (sel < 82)
            begin
                next_start = ($urandom_range(7) == 0);
                put_word(8'($urandom_range(255)));
            end
            else
                next_start = 1'b1;
        end
    endtask

    initial
    begin
        int bpp_set[9]    = '{3, 3, 4, 0, 7, 4, 3, 4, 3};
        int width_set[9]  = '{640, 8, 5, 1, 16, 4096, 8191, 0, 12};
        int height_set[9] = '{480, 4, 3, 1, 8, 4096, 8191, 6, 10};
        restart_parser();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph > 0)
            begin
                write_reg(rlebd_pkg::REG_BPP, 13'(bpp_set[ph]));
                write_reg(rlebd_pkg::REG_WIDTH, 13'(width_set[ph]));
                write_reg(rlebd_pkg::REG_HEIGHT, 13'(height_set[ph]));
                repeat (5) @(posedge clk);
            end
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            @(negedge clk);
            next_start = 1'b1;
            if (ph == 0)
            begin
                // Directed: largest fill, smallest fill, literal, move, new line, end, halted bytes
                put_word(8'd255);
                put_pixel(32'hFFFFFF);
                put_word(8'd1);
                put_pixel(32'h000000);
                put_word(8'd0);
                put_word(8'd3);
                put_pixel(32'h123456);
                put_pixel(32'hABCDEF);
                put_pixel(32'h00FF00);
                put_word(8'd0);
                put_word(8'd2);
                put_word(8'd255);
                put_word(8'd0);
                put_word(8'd0);
                put_word(8'd0);
                put_word(8'd0);
                put_word(8'd1);
                put_word(8'd7);
                put_word(8'd0);
                next_start = 1'b1;
                put_word(8'd0);
                put_word(8'd2);
                put_word(8'd0);
                put_word(8'd255);
            end
            // Hold off the sender until every command of the first half is out
            random_stream(100);
            drain();
            @(negedge clk);
            random_stream(100);
            drain();
        end

        if (mismatches == 0 && expected_cmds.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/rlebd_pkg.sv
hw/rtl/rlebd_front.sv
hw/rtl/rlebd_back.sv
hw/rtl/rle_truecolor_bitmap_decoder_top.sv
verif/tb_top.sv
